// ===== rtl/dfu_pkg.sv =====
package dfu_pkg;

    // Event codes on the input channel
    localparam logic [2:0] OP_SETUP   = 3'd0;
    localparam logic [2:0] OP_ACK     = 3'd1;
    localparam logic [2:0] OP_DONE    = 3'd2;
    localparam logic [2:0] OP_SET_IF  = 3'd3;
    localparam logic [2:0] OP_GET_IF  = 3'd4;
    localparam logic [2:0] OP_BUS_RST = 3'd5;

    // DFU class request codes
    localparam logic [7:0] RQ_DETACH    = 8'd0;
    localparam logic [7:0] RQ_DNLOAD    = 8'd1;
    localparam logic [7:0] RQ_UPLOAD    = 8'd2;
    localparam logic [7:0] RQ_GETSTATUS = 8'd3;
    localparam logic [7:0] RQ_CLRSTATUS = 8'd4;
    localparam logic [7:0] RQ_GETSTATE  = 8'd5;
    localparam logic [7:0] RQ_ABORT     = 8'd6;

    // Configuration register indexes (word address)
    localparam logic [1:0] CFG_CAN_DNLOAD = 2'd0;
    localparam logic [1:0] CFG_CAN_UPLOAD = 2'd1;
    localparam logic [1:0] CFG_MANIF_TOL  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE         = 4'd2,
        ST_DNLOAD_SYNC  = 4'd3,
        ST_DNBUSY       = 4'd4,
        ST_DNLOAD_IDLE  = 4'd5,
        ST_MANIFEST_SYNC = 4'd6,
        ST_MANIFEST     = 4'd7,
        ST_MANIFEST_WR  = 4'd8,
        ST_UPLOAD_IDLE  = 4'd9,
        ST_ERROR        = 4'd10
    } dev_state_t;

    typedef enum logic [2:0] {
        RK_NONE   = 3'd0,
        RK_ACK    = 3'd1,
        RK_STATUS = 3'd2,
        RK_STATE  = 3'd3,
        RK_DATA   = 3'd4,
        RK_UPLOAD = 3'd5,
        RK_ALT    = 3'd6
    } reply_kind_t;

    typedef struct packed {
        logic        can_download;
        logic        can_upload;
        logic        manifest_tolerant;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  request_code;
        logic [15:0] req_length;
        logic [15:0] req_value;
        logic        data_done;
        logic        firmware_valid;
        logic [23:0] poll_timeout_in;
    } item_t;

    typedef struct packed {
        logic        stall_res;
        reply_kind_t reply_kind;
        logic [3:0]  reported_state;
        logic [23:0] poll_timeout_out;
        logic [7:0]  alt_reply;
        logic        deliver_block;
        logic [15:0] block_number;
        logic [15:0] block_length;
        logic        detach_notice;
        logic        abort_notice;
    } res_t;

endpackage

// ===== rtl/dfu_cfg.sv =====
module dfu_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output dfu_pkg::cfg_t     cfg
);

    dfu_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                dfu_pkg::CFG_CAN_DNLOAD: cfg_reg.can_download      <= pwdata[0];
                dfu_pkg::CFG_CAN_UPLOAD: cfg_reg.can_upload        <= pwdata[0];
                dfu_pkg::CFG_MANIF_TOL:  cfg_reg.manifest_tolerant <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            dfu_pkg::CFG_CAN_DNLOAD: prdata[0] = cfg_reg.can_download;
            dfu_pkg::CFG_CAN_UPLOAD: prdata[0] = cfg_reg.can_upload;
            dfu_pkg::CFG_MANIF_TOL:  prdata[0] = cfg_reg.manifest_tolerant;
            default:                 prdata    = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dfu_core.sv =====
module dfu_core #(
    parameter int BUFFER_SIZE = 512
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  dfu_pkg::cfg_t    cfg,
    input  dfu_pkg::item_t   item,
    output dfu_pkg::res_t    res
);

    localparam logic [15:0] BUF_LIM = 16'(BUFFER_SIZE);

    dfu_pkg::dev_state_t state_reg, state_next;
    logic        pend_reg, pend_next;
    logic [7:0]  alt_reg, alt_next;
    logic [15:0] sblk_reg, sblk_next;
    logic [15:0] slen_reg, slen_next;

    logic [7:0]  rq;
    logic [15:0] len;
    logic        rq_known, is_dn, len_ok, slen_ok, plain_setup;

    assign rq       = item.request_code;
    assign len      = item.req_length;
    assign rq_known = rq <= dfu_pkg::RQ_ABORT;
    assign is_dn    = (rq == dfu_pkg::RQ_DNLOAD) && cfg.can_download && (len != 16'd0);
    assign len_ok   = len <= BUF_LIM;
    assign slen_ok  = slen_reg <= BUF_LIM;
    // setup-stage requests handled by the per-state table
    assign plain_setup = rq_known && (rq != dfu_pkg::RQ_DETACH) && (rq != dfu_pkg::RQ_UPLOAD);

    // next state
    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        alt_next   = alt_reg;
        sblk_next  = sblk_reg;
        slen_next  = slen_reg;
        unique case (item.op)
            dfu_pkg::OP_SETUP: begin
                if (plain_setup) begin
                    unique case (state_reg)
                        dfu_pkg::ST_IDLE: begin
                            if (rq == dfu_pkg::RQ_DNLOAD) begin
                                if (is_dn) begin
                                    state_next = dfu_pkg::ST_DNLOAD_SYNC;
                                    pend_next  = 1'b1;
                                end else begin
                                    state_next = dfu_pkg::ST_ERROR;
                                end
                            end else if (rq == dfu_pkg::RQ_CLRSTATUS) begin
                                state_next = dfu_pkg::ST_ERROR;
                            end
                        end
                        dfu_pkg::ST_DNLOAD_SYNC: begin
                            if (rq == dfu_pkg::RQ_GETSTATUS) begin
                                if (pend_reg) begin
                                    state_next = dfu_pkg::ST_DNBUSY;
                                    if (slen_ok) pend_next = 1'b0;
                                end else begin
                                    state_next = dfu_pkg::ST_DNLOAD_IDLE;
                                end
                            end else if (rq != dfu_pkg::RQ_GETSTATE) begin
                                state_next = dfu_pkg::ST_ERROR;
                            end
                        end
                        dfu_pkg::ST_DNLOAD_IDLE: begin
                            priority if (rq == dfu_pkg::RQ_DNLOAD) begin
                                if (is_dn) begin
                                    state_next = dfu_pkg::ST_DNLOAD_SYNC;
                                    pend_next  = 1'b1;
                                end else if (item.data_done) begin
                                    state_next = dfu_pkg::ST_MANIFEST_SYNC;
                                end else begin
                                    state_next = dfu_pkg::ST_ERROR;
                                end
                            end else if (rq == dfu_pkg::RQ_ABORT) begin
                                state_next = dfu_pkg::ST_IDLE;
                            end else if (rq == dfu_pkg::RQ_CLRSTATUS) begin
                                state_next = dfu_pkg::ST_ERROR;
                            end else begin
                            end
                        end
                        dfu_pkg::ST_MANIFEST_SYNC: begin
                            if (rq == dfu_pkg::RQ_GETSTATUS) begin
                                if (!cfg.manifest_tolerant) state_next = dfu_pkg::ST_MANIFEST;
                                else if (item.firmware_valid) state_next = dfu_pkg::ST_IDLE;
                            end else if (rq != dfu_pkg::RQ_GETSTATE) begin
                                state_next = dfu_pkg::ST_ERROR;
                            end
                        end
                        dfu_pkg::ST_MANIFEST, dfu_pkg::ST_MANIFEST_WR: ;
                        dfu_pkg::ST_UPLOAD_IDLE: begin
                            if (rq == dfu_pkg::RQ_ABORT) state_next = dfu_pkg::ST_IDLE;
                        end
                        dfu_pkg::ST_ERROR: begin
                            if (rq == dfu_pkg::RQ_CLRSTATUS) state_next = dfu_pkg::ST_IDLE;
                        end
                        default: state_next = dfu_pkg::ST_ERROR;
                    endcase
                end
            end
            dfu_pkg::OP_ACK: begin
                if (rq == dfu_pkg::RQ_DNLOAD && cfg.can_download &&
                    state_reg == dfu_pkg::ST_DNLOAD_SYNC) begin
                    sblk_next = item.req_value;
                    slen_next = len;
                end
            end
            dfu_pkg::OP_DONE: begin
                if (state_reg == dfu_pkg::ST_DNBUSY) begin
                    state_next = dfu_pkg::ST_DNLOAD_SYNC;
                end else if (state_reg == dfu_pkg::ST_MANIFEST) begin
                    state_next = cfg.manifest_tolerant ? dfu_pkg::ST_MANIFEST_SYNC
                                                       : dfu_pkg::ST_MANIFEST_WR;
                end
            end
            dfu_pkg::OP_SET_IF: begin
                alt_next   = item.req_value[7:0];
                state_next = dfu_pkg::ST_IDLE;
                pend_next  = 1'b0;
            end
            dfu_pkg::OP_BUS_RST: begin
                state_next = dfu_pkg::ST_IDLE;
                pend_next  = 1'b0;
                alt_next   = 8'd0;
            end
            default: ;
        endcase
    end

    // result fields
    always_comb begin
        res = '0;
        res.reply_kind     = dfu_pkg::RK_NONE;
        res.reported_state = 4'(state_next);
        res.alt_reply      = alt_next;
        unique case (item.op)
            dfu_pkg::OP_SETUP: begin
                priority if (!rq_known) begin
                    res.stall_res = 1'b1;
                end else if (rq == dfu_pkg::RQ_DETACH) begin
                    res.reply_kind = dfu_pkg::RK_ACK;
                end else if (rq == dfu_pkg::RQ_UPLOAD) begin
                    if (!cfg.can_upload || !len_ok) begin
                        res.stall_res = 1'b1;
                    end else begin
                        res.reply_kind   = dfu_pkg::RK_UPLOAD;
                        res.block_number = item.req_value;
                        res.block_length = len;
                    end
                end else if (rq == dfu_pkg::RQ_GETSTATUS &&
                             state_reg != dfu_pkg::ST_MANIFEST &&
                             state_reg != dfu_pkg::ST_MANIFEST_WR &&
                             state_reg != dfu_pkg::ST_DNBUSY) begin
                    res.reply_kind       = dfu_pkg::RK_STATUS;
                    res.poll_timeout_out = item.poll_timeout_in;
                    if (state_reg == dfu_pkg::ST_DNLOAD_SYNC && pend_reg && slen_ok) begin
                        res.deliver_block = 1'b1;
                        res.block_number  = sblk_reg;
                        res.block_length  = slen_reg;
                    end
                end else if (rq == dfu_pkg::RQ_GETSTATE &&
                             state_reg != dfu_pkg::ST_MANIFEST &&
                             state_reg != dfu_pkg::ST_MANIFEST_WR &&
                             state_reg != dfu_pkg::ST_DNBUSY) begin
                    res.reply_kind = dfu_pkg::RK_STATE;
                end else if (rq == dfu_pkg::RQ_DNLOAD &&
                             (state_reg == dfu_pkg::ST_IDLE ||
                              state_reg == dfu_pkg::ST_DNLOAD_IDLE)) begin
                    if (is_dn) begin
                        if (len_ok) begin
                            res.reply_kind   = dfu_pkg::RK_DATA;
                            res.block_length = len;
                        end
                    end else if (state_reg == dfu_pkg::ST_DNLOAD_IDLE && item.data_done) begin
                        res.reply_kind = dfu_pkg::RK_ACK;
                    end else begin
                        res.stall_res = 1'b1;
                    end
                end else if (rq == dfu_pkg::RQ_ABORT && state_reg == dfu_pkg::ST_IDLE) begin
                    res.reply_kind = dfu_pkg::RK_ACK;
                end else if (rq == dfu_pkg::RQ_ABORT &&
                             (state_reg == dfu_pkg::ST_DNLOAD_IDLE ||
                              state_reg == dfu_pkg::ST_UPLOAD_IDLE)) begin
                    res.reply_kind   = dfu_pkg::RK_ACK;
                    res.abort_notice = 1'b1;
                end else if (rq == dfu_pkg::RQ_CLRSTATUS && state_reg == dfu_pkg::ST_ERROR) begin
                    res.reply_kind = dfu_pkg::RK_ACK;
                end else begin
                    res.stall_res = 1'b1;
                end
            end
            dfu_pkg::OP_ACK: begin
                if (!rq_known) res.stall_res = 1'b1;
                else if (rq == dfu_pkg::RQ_DETACH) res.detach_notice = 1'b1;
            end
            dfu_pkg::OP_DONE, dfu_pkg::OP_BUS_RST: ;
            dfu_pkg::OP_SET_IF: res.reply_kind = dfu_pkg::RK_ACK;
            dfu_pkg::OP_GET_IF: res.reply_kind = dfu_pkg::RK_ALT;
            default:            res.stall_res  = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dfu_pkg::ST_IDLE;
            pend_reg  <= 1'b0;
            alt_reg   <= 8'd0;
            sblk_reg  <= 16'd0;
            slen_reg  <= 16'd0;
        end else if (step) begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            alt_reg   <= alt_next;
            sblk_reg  <= sblk_next;
            slen_reg  <= slen_next;
        end
    end

    // a block is handed over only out of download-sync with a fitting length
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.deliver_block |-> state_reg == dfu_pkg::ST_DNLOAD_SYNC && slen_ok)
        else $error("block delivered outside download sync");

    // a delivered block is no longer pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.deliver_block |=> !pend_reg)
        else $error("pending flag kept after delivery");

    // manifest and manifest-wait-reset states only leave through the completion notice or reset/set interface
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.op == dfu_pkg::OP_SETUP && state_reg == dfu_pkg::ST_MANIFEST_WR
        |=> state_reg == dfu_pkg::ST_MANIFEST_WR)
        else $error("left manifest-wait-reset on a request");

endmodule

// ===== rtl/usb_dfu_request_state_machine.sv =====
// DFU 1.1 device request state machine.
// Input channel (s_*): one event per transaction: class request setup or
// acknowledge stage, download-complete notice, set-interface or
// get-interface request, or bus reset. Result channel (m_*): exactly one
// result per event with stall flag, reply kind, resulting DFU state, poll
// timeout, alternate setting and the block/detach/abort notices.
// Configuration: APB port, word registers 0 can_download, 1 can_upload,
// 2 manifest_tolerant (bit 0). The user must write them only while no event
// is in flight; the block itself does not enforce this. An accepted event is
// captured in the input register, then the state and result register update.
// Throughput: one event per cycle while results are taken; the state update
// is a single combinational pass between the input and result registers.
// A stalled receiver holds the result register; the input register keeps
// one more event, after which s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): state dfuIDLE, pending cleared,
// alternate setting, saved block and length zero, registers zero, both
// pipeline stages empty.
module usb_dfu_request_state_machine #(
    parameter int BUFFER_SIZE = 512
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [7:0]  s_request_code,
    input  logic [15:0] s_req_length,
    input  logic [15:0] s_req_value,
    input  logic        s_data_done,
    input  logic        s_firmware_valid,
    input  logic [23:0] s_poll_timeout_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_stall_res,
    output logic [2:0]  m_reply_kind,
    output logic [3:0]  m_reported_state,
    output logic [23:0] m_poll_timeout_out,
    output logic [7:0]  m_alt_reply,
    output logic        m_deliver_block,
    output logic [15:0] m_block_number,
    output logic [15:0] m_block_length,
    output logic        m_detach_notice,
    output logic        m_abort_notice
);

    dfu_pkg::cfg_t  cfg;
    dfu_pkg::item_t item_reg;
    dfu_pkg::res_t  res, res_reg;
    logic           in_valid_reg, in_valid_next;
    logic           out_valid_reg, out_valid_next;
    logic           step;

    dfu_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dfu_core #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg),
        .item    (item_reg),
        .res     (res)
    );

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) in_valid_next = 1'b1;
        else if (step)          in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)         out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.op              <= s_op;
            item_reg.request_code    <= s_request_code;
            item_reg.req_length      <= s_req_length;
            item_reg.req_value       <= s_req_value;
            item_reg.data_done       <= s_data_done;
            item_reg.firmware_valid  <= s_firmware_valid;
            item_reg.poll_timeout_in <= s_poll_timeout_in;
        end
        if (step) res_reg <= res;
    end

    assign m_valid            = out_valid_reg;
    assign m_stall_res        = res_reg.stall_res;
    assign m_reply_kind       = 3'(res_reg.reply_kind);
    assign m_reported_state   = res_reg.reported_state;
    assign m_poll_timeout_out = res_reg.poll_timeout_out;
    assign m_alt_reply        = res_reg.alt_reply;
    assign m_deliver_block    = res_reg.deliver_block;
    assign m_block_number     = res_reg.block_number;
    assign m_block_length     = res_reg.block_length;
    assign m_detach_notice    = res_reg.detach_notice;
    assign m_abort_notice     = res_reg.abort_notice;

    assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stall_res |-> m_reply_kind == 3'(dfu_pkg::RK_NONE))
        else $error("stalled request carries a reply");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reply_kind != 3'(dfu_pkg::RK_STATUS) |-> m_poll_timeout_out == 24'd0)
        else $error("poll timeout outside status reply");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_reported_state >= 4'(dfu_pkg::ST_IDLE) &&
                    m_reported_state <= 4'(dfu_pkg::ST_ERROR))
        else $error("reported state out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid && !m_ready)
        else $error("input blocked without a stalled result");

endmodule
